FILE: rtl/bto_pkg.sv
// ----------------------------------------------------------------------------
// bto_pkg
// shared types and constants of the binomial tree option pricer
// ----------------------------------------------------------------------------
package bto_pkg;

    localparam int unsigned BTO_MAX_STEPS = 1024;
    localparam int unsigned PRICE_W       = 32;
    localparam int unsigned ACC_W         = 64;
    localparam int unsigned CFG_IDX_W     = 4;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned STEP_W        = 11;

    localparam logic [PRICE_W-1:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [PRICE_W-1:0] Q30_HALF = 32'h2000_0000;
    localparam logic [PRICE_W-1:0] SAT32    = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_FACTOR    = 4'd0,
        CFG_DOWN_FACTOR  = 4'd1,
        CFG_UP_WEIGHT    = 4'd2,
        CFG_DOWN_WEIGHT  = 4'd3,
        CFG_INV_DISCOUNT = 4'd4,
        CFG_STEP_COUNT   = 4'd5,
        CFG_PUT_MODE     = 4'd6,
        CFG_AMERICAN     = 4'd7
    } cfg_idx_t;

    // control that travels with one multiply into the arithmetic unit
    typedef struct packed {
        logic valid;
        logic accum;
        logic last;
    } bto_issue_t;

endpackage

FILE: rtl/bto_if.sv
// ----------------------------------------------------------------------------
// bto_in_if / bto_out_if
// valid/ready channels for option inputs and priced results
// ----------------------------------------------------------------------------
interface bto_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] spot_price;
    logic [31:0] strike;

    modport source (output valid, output spot_price, output strike, input ready);
    modport sink (input valid, input spot_price, input strike, output ready);
endinterface

interface bto_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] option_value;

    modport source (output valid, output option_value, input ready);
    modport sink (input valid, input option_value, output ready);
endinterface

FILE: rtl/bto_mem.sv
// ----------------------------------------------------------------------------
// bto_mem
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module bto_mem #(
    parameter int unsigned DEPTH = 1025,
    parameter int unsigned AW    = 11,
    parameter int unsigned DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bto_mac.sv
// ----------------------------------------------------------------------------
// bto_mac
// multiply, accumulate, round and saturate pipeline
// ----------------------------------------------------------------------------
module bto_mac
    import bto_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bto_issue_t         issue,
    input  logic [PRICE_W-1:0] op_a,
    input  logic [PRICE_W-1:0] op_b,
    output logic [PRICE_W-1:0] res,
    output logic               res_valid
);

    bto_issue_t         s1_reg;
    bto_issue_t         s2_reg;
    logic               s3_valid_reg;
    logic [ACC_W-1:0]   prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [PRICE_W-1:0] res_reg;
    logic [ACC_W:0]     rnd;
    logic [ACC_W-30:0]  shifted;
    logic [PRICE_W-1:0] sat_next;

    // round half up, drop 30 fraction bits, clamp at the price maximum
    always_comb
    begin
        rnd      = {1'b0, acc_reg} + {{(ACC_W-PRICE_W+1){1'b0}}, Q30_HALF};
        shifted  = rnd[ACC_W:30];
        sat_next = (shifted > {{(ACC_W-30-PRICE_W+1){1'b0}}, SAT32}) ? SAT32
                 : shifted[PRICE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg       <= issue;
            s2_reg       <= s1_reg;
            s3_valid_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {{(ACC_W-PRICE_W){1'b0}}, op_a} * {{(ACC_W-PRICE_W){1'b0}}, op_b};
        acc_reg  <= prod_reg + (s1_reg.accum ? acc_reg : '0);
        res_reg  <= sat_next;
    end

    assign res       = res_reg;
    assign res_valid = s3_valid_reg;

endmodule

FILE: rtl/binomial_tree_option_pricer.sv
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer
// cox-ross-rubinstein option pricer over a node value memory
// ----------------------------------------------------------------------------
// One option per transfer: the block builds the lowest-node price chain S*d^i
// into a chain memory, fills the terminal payoffs into the node memory, then
// walks back level by level, one node at a time, using one shared 32x32
// multiply/accumulate unit. In american mode every backward node but the top
// one of a level also steps the node price up twice. A new input is taken
// once the previous result sits in the output register.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer
    import bto_pkg::*;
#(
    parameter int unsigned MAX_STEPS = BTO_MAX_STEPS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bto_in_if.sink                in_ch,
    bto_out_if.source             out_ch
);

    localparam int unsigned DEPTH = MAX_STEPS + 1;
    localparam int unsigned IDX_W = $clog2(DEPTH);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_CH_ISS  = 14'b00000000000010,
        S_CH_WAIT = 14'b00000000000100,
        S_TERM    = 14'b00000000001000,
        S_TU_ISS  = 14'b00000000010000,
        S_TU_WAIT = 14'b00000000100000,
        S_LV_RD   = 14'b00000001000000,
        S_LV_LD   = 14'b00000010000000,
        S_ND_RD   = 14'b00000100000000,
        S_ND_LD   = 14'b00001000000000,
        S_ND_ISS2 = 14'b00010000000000,
        S_ND_WSUM = 14'b00100000000000,
        S_ND_WDIS = 14'b01000000000000,
        S_ND_NEXT = 14'b10000000000000
    } state_t;

    // the up-step after a backward node reuses the terminal up-step states
    // through a flag that says which phase owns them
    state_t             state_reg, state_next;

    // configuration
    logic [31:0]        up_factor_reg;
    logic [30:0]        down_factor_reg;
    logic [30:0]        up_weight_reg;
    logic [30:0]        down_weight_reg;
    logic [30:0]        inv_discount_reg;
    logic [STEP_W-1:0]  step_count_reg;
    logic               put_mode_reg;
    logic               american_reg;

    // working registers
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   lvl_reg, lvl_next;
    logic               second_reg, second_next;
    logic               back_reg, back_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [PRICE_W-1:0] k_reg, k_next;
    logic [PRICE_W-1:0] a_reg, a_next;
    logic [PRICE_W-1:0] b_reg, b_next;
    logic [PRICE_W-1:0] result_reg, result_next;
    logic               done_reg, done_next;
    logic               out_valid_reg;
    logic [PRICE_W-1:0] out_data_reg;

    // arithmetic unit
    bto_issue_t         issue;
    logic [PRICE_W-1:0] mul_a, mul_b;
    logic [PRICE_W-1:0] mac_res;
    logic               mac_valid;

    // memories
    logic               nv_we, lc_we;
    logic [IDX_W-1:0]   nv_waddr, lc_waddr, nv_raddr, lc_raddr;
    logic [PRICE_W-1:0] nv_wdata, lc_wdata, nv_rdata, lc_rdata;

    logic [IDX_W-1:0]   n_clamp;
    logic [PRICE_W-1:0] payoff_v;
    logic [PRICE_W-1:0] node_v;
    logic               accept;
    logic               out_free;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // step count above MAX_STEPS is cut to that maximum
    assign n_clamp = ({{(32-STEP_W){1'b0}}, step_count_reg} > 32'(MAX_STEPS))
                   ? IDX_W'(MAX_STEPS) : IDX_W'(step_count_reg);

    // exercise value of the current node price
    always_comb
    begin
        if (put_mode_reg)
        begin
            payoff_v = (k_reg > price_reg) ? k_reg - price_reg : '0;
        end
        else
        begin
            payoff_v = (price_reg > k_reg) ? price_reg - k_reg : '0;
        end
    end

    // discounted continuation value, floored at exercise in american mode
    assign node_v = (american_reg && payoff_v > mac_res) ? payoff_v : mac_res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg    <= Q30_ONE;
            down_factor_reg  <= Q30_ONE[30:0];
            up_weight_reg    <= Q30_HALF[30:0];
            down_weight_reg  <= Q30_HALF[30:0];
            inv_discount_reg <= Q30_ONE[30:0];
            step_count_reg   <= STEP_W'(1);
            put_mode_reg     <= 1'b0;
            american_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UP_FACTOR:    up_factor_reg    <= cfg_data;
                CFG_DOWN_FACTOR:  down_factor_reg  <= cfg_data[30:0];
                CFG_UP_WEIGHT:    up_weight_reg    <= cfg_data[30:0];
                CFG_DOWN_WEIGHT:  down_weight_reg  <= cfg_data[30:0];
                CFG_INV_DISCOUNT: inv_discount_reg <= cfg_data[30:0];
                CFG_STEP_COUNT:   step_count_reg   <= cfg_data[STEP_W-1:0];
                CFG_PUT_MODE:     put_mode_reg     <= cfg_data[0];
                CFG_AMERICAN:     american_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        lvl_next    = lvl_reg;
        second_next = second_reg;
        back_next   = back_reg;
        price_next  = price_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        result_next = result_reg;
        done_next   = done_reg;
        issue       = '0;
        mul_a       = price_reg;
        mul_b       = up_factor_reg;
        nv_we       = 1'b0;
        nv_waddr    = j_reg;
        nv_wdata    = payoff_v;
        nv_raddr    = j_reg + IDX_W'(1);
        lc_we       = 1'b0;
        lc_waddr    = j_reg;
        lc_wdata    = mac_res;
        lc_raddr    = lvl_reg - IDX_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    // park the result until the output register is free
                    if (out_free)
                    begin
                        done_next = 1'b0;
                    end
                end
                else if (accept)
                begin
                    price_next = in_ch.spot_price;
                    k_next     = in_ch.strike;
                    n_next     = n_clamp;
                    lc_we      = 1'b1;
                    lc_waddr   = '0;
                    lc_wdata   = in_ch.spot_price;
                    j_next     = (n_clamp == '0) ? '0 : IDX_W'(1);
                    state_next = (n_clamp == '0) ? S_TERM : S_CH_ISS;
                end
            end
            S_CH_ISS:
            begin
                mul_b      = {1'b0, down_factor_reg};
                issue      = '{valid: 1'b1, accum: 1'b0, last: 1'b1};
                state_next = S_CH_WAIT;
            end
            S_CH_WAIT:
            begin
                if (mac_valid)
                begin
                    price_next = mac_res;
                    lc_we      = 1'b1;
                    if (j_reg == n_reg)
                    begin
                        j_next     = '0;
                        state_next = S_TERM;
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_CH_ISS;
                    end
                end
            end
            S_TERM:
            begin
                nv_we = 1'b1;
                if (j_reg == n_reg)
                begin
                    if (n_reg == '0)
                    begin
                        result_next = payoff_v;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        lvl_next   = n_reg;
                        state_next = S_LV_RD;
                    end
                end
                else
                begin
                    second_next = 1'b0;
                    back_next   = 1'b0;
                    state_next  = S_TU_ISS;
                end
            end
            S_TU_ISS:
            begin
                issue      = '{valid: 1'b1, accum: 1'b0, last: 1'b1};
                state_next = S_TU_WAIT;
            end
            S_TU_WAIT:
            begin
                if (mac_valid)
                begin
                    price_next = mac_res;
                    if (!second_reg)
                    begin
                        second_next = 1'b1;
                        state_next  = S_TU_ISS;
                    end
                    else if (back_reg)
                    begin
                        state_next = S_ND_NEXT;
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_TERM;
                    end
                end
            end
            S_LV_RD:
            begin
                nv_raddr   = '0;
                j_next     = '0;
                state_next = S_LV_LD;
            end
            S_LV_LD:
            begin
                a_next     = nv_rdata;
                price_next = lc_rdata;
                state_next = S_ND_RD;
            end
            S_ND_RD:
            begin
                state_next = S_ND_LD;
            end
            S_ND_LD:
            begin
                b_next     = nv_rdata;
                mul_a      = a_reg;
                mul_b      = {1'b0, down_weight_reg};
                issue      = '{valid: 1'b1, accum: 1'b0, last: 1'b0};
                state_next = S_ND_ISS2;
            end
            S_ND_ISS2:
            begin
                mul_a      = b_reg;
                mul_b      = {1'b0, up_weight_reg};
                issue      = '{valid: 1'b1, accum: 1'b1, last: 1'b1};
                state_next = S_ND_WSUM;
            end
            S_ND_WSUM:
            begin
                if (mac_valid)
                begin
                    mul_a      = mac_res;
                    mul_b      = {1'b0, inv_discount_reg};
                    issue      = '{valid: 1'b1, accum: 1'b0, last: 1'b1};
                    state_next = S_ND_WDIS;
                end
            end
            S_ND_WDIS:
            begin
                if (mac_valid)
                begin
                    nv_we    = 1'b1;
                    nv_wdata = node_v;
                    if (lvl_reg == IDX_W'(1))
                    begin
                        result_next = node_v;
                    end
                    if (american_reg && j_reg != lvl_reg - IDX_W'(1))
                    begin
                        second_next = 1'b0;
                        back_next   = 1'b1;
                        state_next  = S_TU_ISS;
                    end
                    else
                    begin
                        state_next = S_ND_NEXT;
                    end
                end
            end
            S_ND_NEXT:
            begin
                a_next = b_reg;
                if (j_reg == lvl_reg - IDX_W'(1))
                begin
                    if (lvl_reg == IDX_W'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg - IDX_W'(1);
                        state_next = S_LV_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_ND_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            back_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            second_reg <= second_next;
            back_reg   <= back_next;
            // load the output register when a finished result is parked
            if (state_reg == S_IDLE && done_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        j_reg      <= j_next;
        lvl_reg    <= lvl_next;
        price_reg  <= price_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        result_reg <= result_next;
        if (state_reg == S_IDLE && done_reg && out_free)
        begin
            out_data_reg <= result_reg;
        end
    end

    assign in_ch.ready         = (state_reg == S_IDLE) && !done_reg;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.option_value = out_data_reg;

    bto_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .op_a      (mul_a),
        .op_b      (mul_b),
        .res       (mac_res),
        .res_valid (mac_valid)
    );

    // node values
    bto_mem #(
        .DEPTH (DEPTH),
        .AW    (IDX_W),
        .DW    (PRICE_W)
    ) u_node_mem (
        .clk   (clk),
        .we    (nv_we),
        .waddr (nv_waddr),
        .wdata (nv_wdata),
        .raddr (nv_raddr),
        .rdata (nv_rdata)
    );

    // lowest node price of each level
    bto_mem #(
        .DEPTH (DEPTH),
        .AW    (IDX_W),
        .DW    (PRICE_W)
    ) u_chain_mem (
        .clk   (clk),
        .we    (lc_we),
        .waddr (lc_waddr),
        .wdata (lc_wdata),
        .raddr (lc_raddr),
        .rdata (lc_rdata)
    );

    // a transfer in is only taken with the sequencer idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("input taken while an item is in flight");

    // node memory writes stay inside the active tree
    a_node_addr: assert property (@(posedge clk) disable iff (!rst_n)
        nv_we |-> nv_waddr <= n_reg)
        else $error("node write beyond the tree");

    // unit results only arrive while the sequencer waits on one
    a_mac_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_valid |-> (state_reg == S_CH_WAIT || state_reg == S_TU_WAIT
                       || state_reg == S_ND_WSUM || state_reg == S_ND_WDIS))
        else $error("unexpected multiply result");

    // a new result appears only from a parked one
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done_reg))
        else $error("result without a finished item");

endmodule
